// ===== src/tsm_pkg.sv =====
// Shared types and constants of the six-axis thruster mixer.
// No dependencies; every other file imports it.
package tsm_pkg;

   localparam int AXES     = 7;
   localparam int DIR_SLOT = 6;
   localparam int CMDS     = 6;

   localparam logic [1:0] REG_THROTTLE_LIMIT = 2'd0;
   localparam logic [1:0] REG_CURRENT_MAX    = 2'd1;
   localparam logic [1:0] REG_RATIO_SCALE    = 2'd2;
   localparam logic [1:0] REG_LIMIT_GAIN     = 2'd3;

   localparam logic FUNC_MIX  = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   localparam logic [16:0] SCALE_ONE  = 17'd65536;
   localparam logic [35:0] RATIO_HIGH = 36'd163840;

   typedef struct packed {
      logic               func;
      logic signed [15:0] roll_cmd;
      logic signed [15:0] pitch_cmd;
      logic signed [15:0] yaw_cmd;
      logic signed [15:0] throttle_cmd;
      logic signed [15:0] forward_cmd;
      logic signed [15:0] lateral_cmd;
      logic        [15:0] battery_current;
      logic               current_valid;
      logic        [2:0]  coef_motor;
      logic        [2:0]  coef_axis;
      logic signed [15:0] coef_value;
   } req_item_type;

   typedef struct packed {
      logic        [2:0]  motor_index;
      logic signed [15:0] motor_thrust;
      logic               roll_limited;
      logic               pitch_limited;
      logic               throttle_low_limited;
      logic               throttle_high_limited;
      logic               last_motor;
   } rsp_item_type;

   typedef struct packed {
      logic [14:0] throttle_limit;
      logic [15:0] current_max;
      logic [23:0] current_ratio_scale;
      logic [15:0] limit_gain;
   } cfg_type;

   typedef struct packed {
      logic                          is_load;
      logic [CMDS-1:0][15:0]         cmd;
      logic                          roll_limited;
      logic                          pitch_limited;
      logic                          throttle_low_limited;
      logic                          throttle_high_limited;
      logic [15:0]                   current;
      logic                          current_valid;
      logic [2:0]                    coef_motor;
      logic [2:0]                    coef_axis;
      logic [15:0]                   coef_value;
   } q_item_type;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_LIM0 = 10'b0000000010,
      ST_LIM1 = 10'b0000000100,
      ST_LIM2 = 10'b0000001000,
      ST_LIM3 = 10'b0000010000,
      ST_LIM4 = 10'b0000100000,
      ST_MAC  = 10'b0001000000,
      ST_FIN  = 10'b0010000000,
      ST_SCL  = 10'b0100000000,
      ST_OUT  = 10'b1000000000
   } state_type;

endpackage

// ===== src/tsm_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on tsm_pkg.
interface tsm_req_if import tsm_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tsm_rsp_if import tsm_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/six_dof_thruster_mixer_unit.sv =====
// Top level of the six-axis thruster mixer: register block and channel wiring.
// Depends on tsm_pkg, tsm_if, tsm_front, tsm_queue and tsm_back.
//
//   channel   direction  handshake              payload
//   req_bus   in         valid/ready            req_item_type
//   rsp_bus   out        valid/ready            rsp_item_type
//   csr       in         APB read/write, pready = 1  4 registers at 4*i
//
// A load beat is written to the table as the engine pops it in idle. A mix
// beat runs limiter states LIM0 to LIM4 when limiting is on, then per motor the
// steps (7 table reads through the single memory port into one multiply-accumulate,
// round, optional scale, output). Reset is synchronous and clears the table
// valid bits at once. A stalled response holds the engine; the two-entry
// queue keeps accepting request beats until full.
module six_dof_thruster_mixer_unit import tsm_pkg::*; #(
   parameter int NUM_MOTORS = 8
) (
   input  logic        clock,
   input  logic        reset,
   tsm_req_if.sink     req_bus,
   tsm_rsp_if.source   rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   cfg_type    cfg_ff, cfg_in;
   logic       q_push;
   logic       q_pop;
   logic       q_full;
   logic       q_empty;
   q_item_type q_item;
   q_item_type q_head;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_THROTTLE_LIMIT: cfg_in.throttle_limit      = pwdata[14:0];
            REG_CURRENT_MAX:    cfg_in.current_max         = pwdata[15:0];
            REG_RATIO_SCALE:    cfg_in.current_ratio_scale = pwdata[23:0];
            REG_LIMIT_GAIN:     cfg_in.limit_gain          = pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_THROTTLE_LIMIT: prdata = {17'b0, cfg_ff.throttle_limit};
         REG_CURRENT_MAX:    prdata = {16'b0, cfg_ff.current_max};
         REG_RATIO_SCALE:    prdata = {8'b0, cfg_ff.current_ratio_scale};
         REG_LIMIT_GAIN:     prdata = {16'b0, cfg_ff.limit_gain};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_limit      <= 15'd32767;
         cfg_ff.current_max         <= 16'd0;
         cfg_ff.current_ratio_scale <= 24'd0;
         cfg_ff.limit_gain          <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsm_front u_front (
      .req            (req_bus),
      .throttle_limit (cfg_ff.throttle_limit),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_item)
   );

   tsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   tsm_back #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );
endmodule

// ===== src/tsm_front.sv =====
// Front end: accepts request beats, clamps the throttle command, sets limit flags.
// Depends on tsm_pkg and tsm_if.
module tsm_front import tsm_pkg::*; (
   tsm_req_if.sink    req,
   input  logic [14:0] throttle_limit,
   input  logic        q_full,
   output logic        q_push,
   output q_item_type  q_item
);
   logic signed [16:0] lim;
   logic signed [16:0] neg_lim;
   logic signed [16:0] thr;
   logic signed [16:0] thr_a;
   logic signed [16:0] thr_b;
   logic               low_hit;
   logic               high_hit;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      lim      = $signed({2'b00, throttle_limit});
      neg_lim  = -lim;
      thr      = 17'(req.data.throttle_cmd);
      low_hit  = thr <= neg_lim;
      thr_a    = low_hit ? neg_lim : thr;
      high_hit = thr_a >= lim;
      thr_b    = high_hit ? lim : thr_a;

      q_item.is_load               = req.data.func == FUNC_LOAD;
      q_item.cmd[0]                = req.data.roll_cmd;
      q_item.cmd[1]                = req.data.pitch_cmd;
      q_item.cmd[2]                = req.data.yaw_cmd;
      q_item.cmd[3]                = thr_b[15:0];
      q_item.cmd[4]                = req.data.forward_cmd;
      q_item.cmd[5]                = req.data.lateral_cmd;
      q_item.roll_limited          = req.data.roll_cmd == 16'sh8000;
      q_item.pitch_limited         = req.data.pitch_cmd == 16'sh8000;
      q_item.throttle_low_limited  = low_hit;
      q_item.throttle_high_limited = high_hit;
      q_item.current               = req.data.battery_current;
      q_item.current_valid         = req.data.current_valid;
      q_item.coef_motor            = req.data.coef_motor;
      q_item.coef_axis             = req.data.coef_axis;
      q_item.coef_value            = req.data.coef_value;
   end
endmodule

// ===== src/tsm_queue.sv =====
// Two-entry queue between front end and mixing engine.
// Depends on tsm_pkg.
module tsm_queue import tsm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_item_type push_item,
   input  logic       pop,
   output q_item_type head,
   output logic       empty,
   output logic       full
);
   q_item_type entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign empty = count_ff == 2'd0;
   assign full  = count_ff == 2'd2;
   assign head  = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end
endmodule

// ===== src/tsm_back.sv =====
// Mixing engine: coefficient table, current limiter, shared multiply-accumulate.
// Depends on tsm_pkg and tsm_if.
module tsm_back import tsm_pkg::*; #(
   parameter int NUM_MOTORS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  q_item_type head,
   input  logic       q_empty,
   output logic       q_pop,
   tsm_rsp_if.source  rsp
);
   localparam int DEPTH = NUM_MOTORS * AXES;
   localparam int AW    = $clog2(DEPTH);
   localparam int MW    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

   state_type state_ff, state_in;
   q_item_type item_ff, item_in;
   logic [MW-1:0] motor_ff, motor_in;
   logic [2:0]    step_ff, step_in;
   logic          lim_on_ff, lim_on_in;

   logic [15:0]      mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [15:0]      rd_ff;
   logic             rvld_ff;
   logic             mem_we;
   logic [AW-1:0]    wa;
   logic [AW-1:0]    ra;
   logic [2:0]       ax;
   logic signed [15:0] rd_word;

   logic signed [15:0] dir_ff, dir_in;
   logic signed [34:0] acc_ff, acc_in;
   logic signed [15:0] thrust_ff, thrust_in;
   logic               scaled_ff, scaled_in;
   logic signed [33:0] sp_ff, sp_in;

   logic [15:0]        prev_ff, prev_in;
   logic [16:0]        os_ff, os_in;
   logic signed [20:0] pred_ff, pred_in;
   logic [39:0]        pa_ff, pa_in;
   logic signed [45:0] pb_ff, pb_in;
   logic               big_ff, big_in;
   logic               mid_ff, mid_in;
   logic signed [37:0] diff_ff, diff_in;
   logic signed [54:0] gp_ff, gp_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;
   logic               out_free;
   logic               out_fire;
   logic               is_last;

   logic [2:0]         cidx;
   logic signed [31:0] prod;
   logic signed [34:0] sgn;
   logic signed [34:0] rnd;
   logic signed [33:0] srnd;
   logic signed [15:0] final_thrust;
   logic signed [23:0] pred2;
   logic signed [23:0] max3;
   logic [35:0]        ratio;
   logic signed [39:0] os_t;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign is_last   = 32'(motor_ff) == NUM_MOTORS - 1;
   assign out_fire  = (state_ff == ST_OUT) && out_free;

   assign q_pop  = (state_ff == ST_IDLE) && !q_empty;
   assign mem_we = q_pop && head.is_load && (32'(head.coef_axis) < AXES)
                   && (32'(head.coef_motor) < NUM_MOTORS);
   assign wa     = AW'(int'(head.coef_motor) * AXES + int'(head.coef_axis));
   assign ax     = (step_ff == 3'd0) ? 3'(DIR_SLOT) : step_ff - 3'd1;
   assign ra     = AW'(int'(motor_ff) * AXES + int'(ax));
   assign rd_word = rvld_ff ? $signed(rd_ff) : 16'sd0;

   always_comb begin
      vld_in = vld_ff;
      if (mem_we) begin
         vld_in[wa] = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      motor_in  = motor_ff;
      step_in   = step_ff;
      lim_on_in = lim_on_ff;
      dir_in    = dir_ff;
      acc_in    = acc_ff;
      thrust_in = thrust_ff;
      scaled_in = scaled_ff;
      sp_in     = sp_ff;
      prev_in   = prev_ff;
      os_in     = os_ff;
      pred_in   = pred_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      big_in    = big_ff;
      mid_in    = mid_ff;
      diff_in   = diff_ff;
      gp_in     = gp_ff;

      cidx  = step_ff - 3'd2;
      prod  = $signed(item_ff.cmd[cidx]) * rd_word;
      sgn   = (dir_ff < 0) ? -acc_ff : acc_ff;
      rnd   = (sgn + 35'sd8192) >>> 14;
      srnd  = (sp_ff + 34'sd32768) >>> 16;
      pred2 = 24'(pred_ff) * 24'sd2;
      max3  = $signed({8'b0, cfg.current_max}) * 24'sd3;
      ratio = big_ff ? RATIO_HIGH
              : (mid_ff ? 36'(pb_ff[45:8]) : 36'(pa_ff[39:8]));
      os_t  = $signed({23'b0, os_ff}) + 40'((gp_ff + 55'sd32768) >>> 16);

      if (scaled_ff) begin
         if (srnd > 34'sd32767) final_thrust = 16'sh7fff;
         else if (srnd < -34'sd32768) final_thrust = 16'sh8000;
         else final_thrust = srnd[15:0];
      end else begin
         final_thrust = thrust_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && !head.is_load) begin
               item_in   = head;
               motor_in  = '0;
               step_in   = 3'd0;
               lim_on_in = (cfg.current_max != 16'd0) && head.current_valid;
               state_in  = lim_on_in ? ST_LIM0 : ST_MAC;
            end
         end
         ST_LIM0: begin
            pred_in  = $signed({5'b0, item_ff.current}) * 21'sd6
                       - $signed({5'b0, prev_ff}) * 21'sd5;
            pa_in    = 40'(item_ff.current) * 40'(cfg.current_ratio_scale);
            state_in = ST_LIM1;
         end
         ST_LIM1: begin
            pb_in    = 46'(pred_ff) * $signed({22'b0, cfg.current_ratio_scale});
            big_in   = pred2 > max3;
            mid_in   = (item_ff.current < cfg.current_max)
                       && (pred_ff > $signed({5'b0, cfg.current_max}));
            state_in = ST_LIM2;
         end
         ST_LIM2: begin
            diff_in  = 38'sd65536 - $signed({2'b0, ratio});
            state_in = ST_LIM3;
         end
         ST_LIM3: begin
            gp_in    = 55'($signed({1'b0, cfg.limit_gain})) * 55'(diff_ff);
            state_in = ST_LIM4;
         end
         ST_LIM4: begin
            if (os_t < 0) os_in = '0;
            else if (os_t > 40'sd65536) os_in = SCALE_ONE;
            else os_in = os_t[16:0];
            prev_in  = item_ff.current;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (step_ff == 3'd0) acc_in = '0;
            if (step_ff == 3'd1) dir_in = rd_word;
            if (step_ff >= 3'd2) acc_in = acc_ff + 35'(prod);
            if (step_ff == 3'd7) begin
               state_in = ST_FIN;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_FIN: begin
            if (dir_ff == 16'sd0) thrust_in = 16'sd0;
            else if (rnd > 35'sd32767) thrust_in = 16'sh7fff;
            else if (rnd < -35'sd32768) thrust_in = 16'sh8000;
            else thrust_in = rnd[15:0];
            scaled_in = lim_on_ff && (dir_ff != 16'sd0);
            state_in  = scaled_in ? ST_SCL : ST_OUT;
         end
         ST_SCL: begin
            sp_in    = 34'(thrust_ff) * $signed({17'b0, os_ff});
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               step_in = 3'd0;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  motor_in = motor_ff + 1'b1;
                  state_in = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      if (out_fire) begin
         rsp_valid_in                      = 1'b1;
         rsp_data_in.motor_index           = 3'(motor_ff);
         rsp_data_in.motor_thrust          = final_thrust;
         rsp_data_in.roll_limited          = item_ff.roll_limited;
         rsp_data_in.pitch_limited         = item_ff.pitch_limited;
         rsp_data_in.throttle_low_limited  = item_ff.throttle_low_limited;
         rsp_data_in.throttle_high_limited = item_ff.throttle_high_limited;
         rsp_data_in.last_motor            = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         motor_ff     <= '0;
         step_ff      <= 3'd0;
         lim_on_ff    <= 1'b0;
         scaled_ff    <= 1'b0;
         vld_ff       <= '0;
         prev_ff      <= 16'd0;
         os_ff        <= SCALE_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         motor_ff     <= motor_in;
         step_ff      <= step_in;
         lim_on_ff    <= lim_on_in;
         scaled_ff    <= scaled_in;
         vld_ff       <= vld_in;
         prev_ff      <= prev_in;
         os_ff        <= os_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      dir_ff      <= dir_in;
      acc_ff      <= acc_in;
      thrust_ff   <= thrust_in;
      sp_ff       <= sp_in;
      pred_ff     <= pred_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      big_ff      <= big_in;
      mid_ff      <= mid_in;
      diff_ff     <= diff_in;
      gp_ff       <= gp_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[wa] <= head.coef_value;
      end
      rd_ff   <= mem_ff[ra];
      rvld_ff <= vld_ff[ra];
   end

   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      os_ff <= SCALE_ONE) else $error("output scale above one");

   a_motor_range: assert property (@(posedge clock) disable iff (reset)
      32'(motor_ff) < NUM_MOTORS) else $error("motor counter out of range");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (out_fire && is_last) |=> (state_ff == ST_IDLE))
      else $error("run did not end after last motor");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !q_pop) else $error("queue popped while busy");
endmodule
